@@ sv/length_prefixed_frame_receiver_core_defines.svh @@
// assertion helpers used by the frame receiver deframer
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define LPFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfr assertion failed");

// next-cycle implication, checked out of reset
`define LPFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfr assertion failed");

`else

`define LPFR_ASSERT_NOW(label, ante, cons)
`define LPFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ sv/lpfr_pkg.sv @@
package lpfr_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'h7E;
  localparam logic [7:0]  SYNC_SECOND = 8'hA5;
  localparam logic [15:0] CRC_START   = 16'hFFFF;
  localparam logic [15:0] MIN_LENGTH  = 16'd2;

  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;
  localparam logic [15:0] RESIDUE_RESET = 16'hF0B8;

  // register index as decoded from the address word bit
  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_RESIDUE = 1'b1;

  typedef enum logic [2:0] {
    MODE_HUNT1  = 3'd0,
    MODE_HUNT2  = 3'd1,
    MODE_LEN_HI = 3'd2,
    MODE_LEN_LO = 3'd3,
    MODE_DATA   = 3'd4
  } mode_t;

  typedef struct packed {
    logic [15:0] max_frame_length;
    logic [15:0] crc_good_residue;
  } cfg_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } stage_t;

  // reflected crc-16/x.25, one byte per call
  function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  t;
    logic [15:0] w;
    t = crc[7:0] ^ b;
    t = t ^ {t[3:0], 4'b0000};
    w = {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    return {8'h00, crc[15:8]} ^ w;
  endfunction

endpackage

@@ sv/lpfr_stream_ifs.sv @@
interface lpfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfr_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       frame_end;
  logic       crc_ok;

  modport source (output valid, output payload_valid, output payload_byte,
                  output frame_end, output crc_ok, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input frame_end, input crc_ok, output ready);
endinterface

@@ sv/lpfr_cfg_regs.sv @@
module lpfr_cfg_regs
  import lpfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic [15:0] max_len_r;
  logic [15:0] residue_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
      residue_r <= RESIDUE_RESET;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        CFG_MAX_LEN: max_len_r <= cfg_pwdata[15:0];
        CFG_RESIDUE: residue_r <= cfg_pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_MAX_LEN: cfg_prdata = {16'h0000, max_len_r};
      CFG_RESIDUE: cfg_prdata = {16'h0000, residue_r};
      default:     cfg_prdata = 32'h0000_0000;
    endcase
  end

  assign cfg.max_frame_length = max_len_r;
  assign cfg.crc_good_residue = residue_r;

endmodule

@@ sv/lpfr_in_stage.sv @@
module lpfr_in_stage
  import lpfr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  lpfr_in_if.sink in_ch,
  input  logic   advance,
  output stage_t stage
);

  logic       vld_r;
  logic [7:0] byte_r;

  // the held byte leaves whenever the next stage moves, so a new one can enter
  assign in_ch.ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign stage.vld     = vld_r;
  assign stage.rx_byte = byte_r;

endmodule

@@ sv/lpfr_deframer.sv @@
`include "length_prefixed_frame_receiver_core_defines.svh"

module lpfr_deframer
  import lpfr_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  stage_t     stage,
  input  cfg_t       cfg,
  output logic       advance,
  lpfr_out_if.source out_ch
);

  localparam logic [16:0] LenLimit = 17'((17'd1 << LENGTH_WIDTH) - 17'd1);

  mode_t                   mode_r, mode_nxt;
  logic [7:0]              len_hi_r, len_hi_nxt;
  logic [LENGTH_WIDTH-1:0] length_r, length_nxt;
  logic [LENGTH_WIDTH-1:0] count_r, count_nxt;
  logic [15:0]             crc_r, crc_nxt;
  logic [7:0]              held0_r, held0_nxt;
  logic [7:0]              held1_r, held1_nxt;

  logic        out_vld_r;
  logic        pv_r, fe_r, ok_r;
  logic [7:0]  pbyte_r;

  logic        res_pv, res_fe, res_ok;
  logic [7:0]  res_byte;
  logic        proc;
  logic [15:0] len16;
  logic [LENGTH_WIDTH-1:0] count_inc;
  logic [15:0] crc_upd;

  assign advance   = !out_vld_r || out_ch.ready;
  assign proc      = stage.vld && advance;
  assign len16     = {len_hi_r, stage.rx_byte};
  assign count_inc = count_r + 1'b1;
  assign crc_upd   = crc_x25_byte(crc_r, stage.rx_byte);

  always_comb begin
    mode_nxt   = mode_r;
    len_hi_nxt = len_hi_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    held0_nxt  = held0_r;
    held1_nxt  = held1_r;
    res_pv     = 1'b0;
    res_byte   = 8'h00;
    res_fe     = 1'b0;
    res_ok     = 1'b0;
    unique case (mode_r)
      MODE_DATA: begin
        count_nxt = count_inc;
        crc_nxt   = crc_upd;
        // two bytes are held back so the crc never reaches the output
        if (count_inc >= LENGTH_WIDTH'(3)) begin
          res_pv   = 1'b1;
          res_byte = held0_r;
        end
        held0_nxt = held1_r;
        held1_nxt = stage.rx_byte;
        if (count_inc == length_r) begin
          res_fe   = 1'b1;
          res_ok   = (crc_upd == cfg.crc_good_residue);
          mode_nxt = MODE_HUNT1;
        end
      end
      MODE_HUNT2: begin
        mode_nxt = (stage.rx_byte == SYNC_SECOND) ? MODE_LEN_HI : MODE_HUNT1;
      end
      MODE_LEN_HI: begin
        len_hi_nxt = stage.rx_byte;
        mode_nxt   = MODE_LEN_LO;
      end
      MODE_LEN_LO: begin
        length_nxt = len16[LENGTH_WIDTH-1:0];
        if (len16 >= MIN_LENGTH && len16 <= cfg.max_frame_length &&
            {1'b0, len16} <= LenLimit) begin
          mode_nxt  = MODE_DATA;
          count_nxt = '0;
          crc_nxt   = CRC_START;
        end else begin
          mode_nxt = MODE_HUNT1;
        end
      end
      default: begin
        mode_nxt = (stage.rx_byte == SYNC_FIRST) ? MODE_HUNT2 : MODE_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_HUNT1;
      len_hi_r  <= 8'h00;
      length_r  <= '0;
      count_r   <= '0;
      crc_r     <= 16'h0000;
      out_vld_r <= 1'b0;
    end else begin
      if (proc) begin
        mode_r   <= mode_nxt;
        len_hi_r <= len_hi_nxt;
        length_r <= length_nxt;
        count_r  <= count_nxt;
        crc_r    <= crc_nxt;
      end
      if (advance) begin
        out_vld_r <= proc && (res_pv || res_fe);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
    if (advance) begin
      pv_r    <= res_pv;
      pbyte_r <= res_byte;
      fe_r    <= res_fe;
      ok_r    <= res_ok;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.payload_valid = pv_r;
  assign out_ch.payload_byte  = pbyte_r;
  assign out_ch.frame_end     = fe_r;
  assign out_ch.crc_ok        = ok_r;

  `LPFR_ASSERT_NOW(a_beat_has_content, out_vld_r, pv_r || fe_r)
  `LPFR_ASSERT_NOW(a_ok_only_at_end, out_vld_r && ok_r, fe_r)
  `LPFR_ASSERT_NEXT(a_end_rehunts, proc && res_fe, mode_r == MODE_HUNT1)
  `LPFR_ASSERT_NOW(a_count_in_frame, mode_r == MODE_DATA, count_r < length_r)

endmodule

@@ sv/length_prefixed_frame_receiver_core.sv @@
// path: a byte accepted into the input stage register is decoded by the deframer, and its
// result beat, if it gives one, is held in the output register until out_ch takes it
// throughput: one byte per cycle unless out_ch stalls; crc and sync fsm step per byte
// reset: synchronous active-low rst_n returns the fsm to sync hunt, empties both stages
// and loads max_frame_length 1024 and crc_good_residue 0xF0B8
module length_prefixed_frame_receiver_core
  import lpfr_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lpfr_in_if.sink     in_ch,
  lpfr_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t   cfg;
  stage_t stage;
  logic   advance;

  lpfr_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lpfr_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  lpfr_deframer #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .cfg     (cfg),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule
